### sv/ac_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Aho-Corasick automaton builder.
package ac_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = 10;
  localparam int USED_W      = 11;
  localparam int CNT_W       = 16;
  localparam int SYM_W       = 5;
  localparam int GOTO_W      = 11;
  localparam int GOTO_DEPTH  = MAX_NODES * ALPHABET;
  localparam int GOTO_AW     = $clog2(GOTO_DEPTH);

  typedef enum logic [1:0] {
    ACT_SYM    = 2'd0,
    ACT_END    = 2'd1,
    ACT_BUILD  = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_BAD_SYM     = 3'd2,
    ST_AFTER_BUILD = 3'd3,
    ST_BAD_NODE    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_ALPHABET = 1'b0,
    REG_OFFSET   = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    BK_CLEAR, BK_IDLE, BK_RD_CNT, BK_END_WR, BK_INS, BK_LK,
    BK_ROOT_RD, BK_ROOT_EV, BK_POP, BK_CUR, BK_F, BK_CF, BK_CC,
    BK_RDF, BK_RDC, BK_EV
  } back_state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] raw_symbol;
    logic [9:0] node_index;
  } in_t;

  typedef struct packed {
    logic [9:0]  next_node;
    logic [15:0] match_count;
    logic [2:0]  status;
    logic [10:0] node_count;
  } out_t;

  // Decoded item as it travels from the front to the back.
  typedef struct packed {
    action_e           action;
    logic              sym_ok;
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] node;
  } item_t;

  // Alphabet size clamped into 1..ALPHABET.
  function automatic logic [SYM_W-1:0] active_alpha(input logic [4:0] cfg);
    logic [SYM_W-1:0] r;
    if (cfg == 5'd0) begin
      r = SYM_W'(1);
    end else if (cfg > 5'(ALPHABET)) begin
      r = SYM_W'(ALPHABET);
    end else begin
      r = cfg;
    end
    return r;
  endfunction

endpackage

### sv/ac_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ac_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ac_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of decoded items between the front and the back.
module ac_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ac_pkg::item_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ac_pkg::item_t item_o
);

  ac_pkg::item_t mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

### sv/ac_front.sv
`timescale 1ns / 1ps
// Front end: accepts commands, decodes the symbol and feeds the queue.
module ac_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  ac_pkg::in_t   in_i,
  input  logic [4:0]    alph_i,
  input  logic [7:0]    off_i,
  output logic          ready_o,
  input  logic          fifo_full_i,
  output logic          push_o,
  output ac_pkg::item_t item_o
);

  logic          stg_valid_q, stg_valid_d;
  ac_pkg::item_t stg_q, dec;
  logic [7:0]    rel;
  logic [ac_pkg::SYM_W-1:0] alpha;

  assign alpha   = ac_pkg::active_alpha(alph_i);
  assign rel     = in_i.raw_symbol - off_i;
  assign ready_o = !stg_valid_q || !fifo_full_i;
  assign push_o  = stg_valid_q;
  assign item_o  = stg_q;

  always_comb begin
    dec.action = ac_pkg::action_e'(in_i.action);
    dec.sym_ok = (in_i.raw_symbol >= off_i) && (rel < {3'b000, alpha});
    dec.sym    = rel[ac_pkg::SYM_W-1:0];
    dec.node   = in_i.node_index;
    if (take_i) begin
      stg_valid_d = 1'b1;
    end else if (stg_valid_q && !fifo_full_i) begin
      stg_valid_d = 1'b0;
    end else begin
      stg_valid_d = stg_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      stg_q <= dec;
    end
  end

endmodule

### sv/ac_back.sv
`timescale 1ns / 1ps
// Back end: trie insert, breadth-first build pass and lookups over the tables.
module ac_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  input  ac_pkg::item_t item_i,
  output logic          pop_o,
  input  logic [4:0]    alph_i,
  output logic          clearing_o,
  output logic          res_valid_o,
  output ac_pkg::out_t  res_o
);

  localparam int NW = ac_pkg::NODE_W;
  localparam int UW = ac_pkg::USED_W;
  localparam int CW = ac_pkg::CNT_W;
  localparam int GW = ac_pkg::GOTO_W;
  localparam int AW = ac_pkg::GOTO_AW;
  localparam int SW = ac_pkg::SYM_W;

  ac_pkg::back_state_e state_q, state_d;
  logic [NW-1:0] cur_q, cur_d, node_q, node_d, f_q, f_d, res_node_q, res_node_d;
  logic [UW-1:0] used_q, used_d, head_q, head_d, tail_q, tail_d;
  logic          built_q, built_d;
  ac_pkg::status_e res_status_q, res_status_d;
  logic [AW-1:0] ga_q, ga_d, clr_q, clr_d, fbase_q, fbase_d, cbase_q, cbase_d;
  logic [SW-1:0] i_q, i_d, alpha;
  logic [CW-1:0] cf_q, cf_d;
  logic [GW-1:0] fe_q, fe_d, e;
  logic          out_valid_q, out_valid_d;
  ac_pkg::out_t  out_q, out_d;

  logic          g_we, f_we, c_we, q_we;
  logic [AW-1:0] g_waddr, g_raddr;
  logic [GW-1:0] g_wdata, g_rdata;
  logic [NW-1:0] f_waddr, f_wdata, f_raddr, f_rdata;
  logic [NW-1:0] c_waddr, c_raddr, q_waddr, q_wdata, q_raddr, q_rdata;
  logic [CW-1:0] c_wdata, c_rdata;
  logic          last_sym;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [AW-1:0] row_base(input logic [NW-1:0] n);
    return AW'(n) * AW'(ac_pkg::ALPHABET);
  endfunction

  assign alpha    = ac_pkg::active_alpha(alph_i);
  assign last_sym = (i_q == alpha - SW'(1));
  assign e        = g_rdata;

  ac_ram #(.Width(GW), .Depth(ac_pkg::GOTO_DEPTH)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );
  ac_ram #(.Width(NW), .Depth(ac_pkg::MAX_NODES)) u_fail (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );
  ac_ram #(.Width(CW), .Depth(ac_pkg::MAX_NODES)) u_cnt (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );
  ac_ram #(.Width(NW), .Depth(ac_pkg::MAX_NODES)) u_bfsq (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  always_comb begin
    state_d = state_q;  cur_d = cur_q;  node_d = node_q;  f_d = f_q;
    res_node_d = res_node_q;  res_status_d = res_status_q;
    used_d = used_q;  head_d = head_q;  tail_d = tail_q;  built_d = built_q;
    ga_d = ga_q;  clr_d = clr_q;  fbase_d = fbase_q;  cbase_d = cbase_q;
    i_d = i_q;  cf_d = cf_q;  fe_d = fe_q;
    out_valid_d = 1'b0;  out_d = out_q;  pop_o = 1'b0;
    g_we = 1'b0;  g_waddr = '0;  g_wdata = '0;  g_raddr = '0;
    f_we = 1'b0;  f_waddr = '0;  f_wdata = '0;  f_raddr = '0;
    c_we = 1'b0;  c_waddr = '0;  c_wdata = '0;  c_raddr = '0;
    q_we = 1'b0;  q_waddr = '0;  q_wdata = '0;  q_raddr = '0;

    unique case (state_q)
      ac_pkg::BK_CLEAR: begin
        g_we = 1'b1;
        g_waddr = clr_q;
        if (clr_q < AW'(ac_pkg::MAX_NODES)) begin
          c_we = 1'b1;
          c_waddr = clr_q[NW-1:0];
        end
        if (clr_q == AW'(ac_pkg::GOTO_DEPTH - 1)) begin
          state_d = ac_pkg::BK_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ac_pkg::BK_IDLE: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          unique case (item_i.action)
            ac_pkg::ACT_SYM, ac_pkg::ACT_END: begin
              res_node_d = cur_q;
              c_raddr = cur_q;
              if (built_q) begin
                res_status_d = ac_pkg::ST_AFTER_BUILD;
                state_d = ac_pkg::BK_RD_CNT;
              end else if (item_i.action == ac_pkg::ACT_END) begin
                state_d = ac_pkg::BK_END_WR;
              end else if (!item_i.sym_ok) begin
                res_status_d = ac_pkg::ST_BAD_SYM;
                state_d = ac_pkg::BK_RD_CNT;
              end else begin
                ga_d = row_base(cur_q) + AW'(item_i.sym);
                g_raddr = ga_d;
                state_d = ac_pkg::BK_INS;
              end
            end
            ac_pkg::ACT_BUILD: begin
              cur_d = '0;
              if (built_q) begin
                res_node_d = '0;
                res_status_d = ac_pkg::ST_OK;
                state_d = ac_pkg::BK_RD_CNT;
              end else begin
                i_d = '0;
                head_d = '0;
                tail_d = '0;
                state_d = ac_pkg::BK_ROOT_RD;
              end
            end
            ac_pkg::ACT_LOOKUP: begin
              if ({1'b0, item_i.node} >= used_q) begin
                out_valid_d = 1'b1;
                out_d = '{next_node: '0, match_count: '0,
                          status: ac_pkg::ST_BAD_NODE, node_count: used_q};
              end else if (!item_i.sym_ok) begin
                out_valid_d = 1'b1;
                out_d = '{next_node: '0, match_count: '0,
                          status: ac_pkg::ST_BAD_SYM, node_count: used_q};
              end else begin
                g_raddr = row_base(item_i.node) + AW'(item_i.sym);
                state_d = ac_pkg::BK_LK;
              end
            end
            default: ;
          endcase
        end
      end
      ac_pkg::BK_RD_CNT: begin
        out_valid_d = 1'b1;
        out_d = '{next_node: res_node_q, match_count: c_rdata,
                  status: res_status_q, node_count: used_q};
        state_d = ac_pkg::BK_IDLE;
      end
      ac_pkg::BK_END_WR: begin
        c_we = 1'b1;
        c_waddr = cur_q;
        c_wdata = sat_add(c_rdata, CW'(1));
        out_valid_d = 1'b1;
        out_d = '{next_node: cur_q, match_count: c_wdata,
                  status: ac_pkg::ST_OK, node_count: used_q};
        cur_d = '0;
        state_d = ac_pkg::BK_IDLE;
      end
      ac_pkg::BK_INS: begin
        res_status_d = ac_pkg::ST_OK;
        if (e != '0) begin
          cur_d = NW'(e - GW'(1));
          res_node_d = cur_d;
          c_raddr = cur_d;
          state_d = ac_pkg::BK_RD_CNT;
        end else if (used_q >= UW'(ac_pkg::MAX_NODES)) begin
          res_status_d = ac_pkg::ST_FULL;
          res_node_d = cur_q;
          c_raddr = cur_q;
          state_d = ac_pkg::BK_RD_CNT;
        end else begin
          g_we = 1'b1;
          g_waddr = ga_q;
          g_wdata = GW'(used_q + UW'(1));
          c_we = 1'b1;
          c_waddr = used_q[NW-1:0];
          cur_d = used_q[NW-1:0];
          used_d = used_q + UW'(1);
          out_valid_d = 1'b1;
          out_d = '{next_node: used_q[NW-1:0], match_count: '0,
                    status: ac_pkg::ST_OK, node_count: used_d};
          state_d = ac_pkg::BK_IDLE;
        end
      end
      ac_pkg::BK_LK: begin
        if (e == '0) begin
          out_valid_d = 1'b1;
          out_d = '{next_node: '0, match_count: '0,
                    status: ac_pkg::ST_BAD_SYM, node_count: used_q};
          state_d = ac_pkg::BK_IDLE;
        end else begin
          res_node_d = NW'(e - GW'(1));
          res_status_d = ac_pkg::ST_OK;
          c_raddr = res_node_d;
          state_d = ac_pkg::BK_RD_CNT;
        end
      end
      ac_pkg::BK_ROOT_RD: begin
        g_raddr = AW'(i_q);
        state_d = ac_pkg::BK_ROOT_EV;
      end
      ac_pkg::BK_ROOT_EV: begin
        if (e == '0) begin
          // Missing root edges loop back to the root.
          g_we = 1'b1;
          g_waddr = AW'(i_q);
          g_wdata = GW'(1);
        end else begin
          f_we = 1'b1;
          f_waddr = NW'(e - GW'(1));
          if (tail_q < UW'(ac_pkg::MAX_NODES)) begin
            q_we = 1'b1;
            q_waddr = tail_q[NW-1:0];
            q_wdata = NW'(e - GW'(1));
            tail_d = tail_q + UW'(1);
          end
        end
        if (last_sym) begin
          state_d = ac_pkg::BK_POP;
        end else begin
          i_d = i_q + SW'(1);
          state_d = ac_pkg::BK_ROOT_RD;
        end
      end
      ac_pkg::BK_POP: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
          cur_d = '0;
          res_node_d = '0;
          res_status_d = ac_pkg::ST_OK;
          state_d = ac_pkg::BK_RD_CNT;
        end else begin
          q_raddr = head_q[NW-1:0];
          head_d = head_q + UW'(1);
          state_d = ac_pkg::BK_CUR;
        end
      end
      ac_pkg::BK_CUR: begin
        node_d = q_rdata;
        cbase_d = row_base(q_rdata);
        f_raddr = q_rdata;
        state_d = ac_pkg::BK_F;
      end
      ac_pkg::BK_F: begin
        f_d = f_rdata;
        fbase_d = row_base(f_rdata);
        c_raddr = f_rdata;
        state_d = ac_pkg::BK_CF;
      end
      ac_pkg::BK_CF: begin
        cf_d = c_rdata;
        c_raddr = node_q;
        state_d = ac_pkg::BK_CC;
      end
      ac_pkg::BK_CC: begin
        c_we = 1'b1;
        c_waddr = node_q;
        c_wdata = sat_add(c_rdata, cf_q);
        i_d = '0;
        state_d = ac_pkg::BK_RDF;
      end
      ac_pkg::BK_RDF: begin
        g_raddr = fbase_q + AW'(i_q);
        state_d = ac_pkg::BK_RDC;
      end
      ac_pkg::BK_RDC: begin
        fe_d = g_rdata;
        g_raddr = cbase_q + AW'(i_q);
        state_d = ac_pkg::BK_EV;
      end
      ac_pkg::BK_EV: begin
        if (e == '0) begin
          g_we = 1'b1;
          g_waddr = cbase_q + AW'(i_q);
          g_wdata = fe_q;
        end else begin
          f_we = 1'b1;
          f_waddr = NW'(e - GW'(1));
          f_wdata = (fe_q == '0) ? '0 : NW'(fe_q - GW'(1));
          if (tail_q < UW'(ac_pkg::MAX_NODES)) begin
            q_we = 1'b1;
            q_waddr = tail_q[NW-1:0];
            q_wdata = NW'(e - GW'(1));
            tail_d = tail_q + UW'(1);
          end
        end
        if (last_sym) begin
          state_d = ac_pkg::BK_POP;
        end else begin
          i_d = i_q + SW'(1);
          state_d = ac_pkg::BK_RDF;
        end
      end
      default: state_d = ac_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ac_pkg::BK_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      used_q      <= UW'(1);
      built_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      built_q     <= built_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      i_q         <= i_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    f_q          <= f_d;
    res_node_q   <= res_node_d;
    res_status_q <= res_status_d;
    ga_q         <= ga_d;
    fbase_q      <= fbase_d;
    cbase_q      <= cbase_d;
    cf_q         <= cf_d;
    fe_q         <= fe_d;
    out_q        <= out_d;
  end

  assign clearing_o  = (state_q == ac_pkg::BK_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

### sv/aho_corasick_automaton_builder_core.sv
`timescale 1ns / 1ps
// Aho-Corasick automaton builder: pattern insert, build pass and transition lookup.
//
// Commands enter on item_i and are taken at a clock edge with start high and
// busy low. Action 0 adds a symbol to the current pattern, 1 closes it, 2 builds
// the failure links and completes the goto table, 3 looks up a transition.
// Every command yields exactly one result beat: res_valid_o is high for one
// cycle with res_o, and the receiver cannot hold it off.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i only while
// the block is idle; the user must keep to this, the block does not enforce it.
// Index 0 is the alphabet size, index 1 the symbol offset. A command passes a
// registered front stage and a two-entry queue, then the back end. From an idle
// back end, a lookup refused on its node or symbol is answered from BK_IDLE; a new
// node, an end of pattern, an insert refused on its symbol or after a build, a
// repeated build or an empty lookup entry from the state after it; a result that
// needs a count from BK_RD_CNT. Commands run one at a time in the back end; busy
// rises when the queue and the front stage are both full, and while clearing. A
// build walks the root row, then a breadth-first queue, adding each failure count
// and reading the goto rows of node and failure node. After reset the goto table
// and the counts are cleared, one entry a cycle; busy is high during that pass.
module aho_corasick_automaton_builder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  ac_pkg::in_t  item_i,
  output logic         res_valid_o,
  output ac_pkg::out_t res_o,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [7:0]   cfg_data_i
);

  logic [4:0]    alph_q;
  logic [7:0]    off_q;
  logic          front_ready, take, push, fifo_full, q_valid, pop, clearing;
  ac_pkg::item_t push_item, q_item;

  assign busy = !front_ready || clearing;
  assign take = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alph_q <= 5'd26;
      off_q  <= 8'd97;
    end else if (cfg_we_i) begin
      unique case (ac_pkg::cfg_reg_e'(cfg_idx_i))
        ac_pkg::REG_ALPHABET: alph_q <= cfg_data_i[4:0];
        ac_pkg::REG_OFFSET:   off_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ac_front u_front (
    .clk_i, .rst_ni, .take_i(take), .in_i(item_i), .alph_i(alph_q), .off_i(off_q),
    .ready_o(front_ready), .fifo_full_i(fifo_full), .push_o(push), .item_o(push_item)
  );

  ac_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .full_o(fifo_full),
    .pop_i(pop), .valid_o(q_valid), .item_o(q_item)
  );

  ac_back u_back (
    .clk_i, .rst_ni, .item_valid_i(q_valid), .item_i(q_item), .pop_o(pop),
    .alph_i(alph_q), .clearing_o(clearing), .res_valid_o, .res_o
  );

  a_no_beat_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !res_valid_o) else $error("result beat during clearing pass");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.node_count != 11'd0) else $error("node count is zero");

  a_bad_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ac_pkg::ST_BAD_NODE) |->
      (res_o.next_node == 10'd0 && res_o.match_count == 16'd0))
    else $error("bad node result carries data");

endmodule
